/* hdl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int POS_BITS        = 32;
	localparam int OUT_BITS        = 32;
	localparam int CFG_BITS        = 7;

	localparam logic [CFG_BITS-1:0] WS_RESET = CFG_BITS'(3);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// result handed from the sequencer to the output register
	typedef struct packed {
		logic fire;
		logic partial;
	} res_ctl_t;

endpackage

/* hdl/swm_ram.sv */
// ----------------------------------------------------------------------------
// swm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/swm_ctrl.sv */
// ----------------------------------------------------------------------------
// swm_ctrl
// Deque sequencer: drops stale front candidates, pops smaller back
// candidates, appends the new sample and forms the window maximum.
// ----------------------------------------------------------------------------
module swm_ctrl import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [SAMPLE_BITS-1:0]           sample,
	input  logic                                    last_item,
	input  logic [CFG_BITS-1:0]                     k,
	input  logic [SAMPLE_BITS+POS_BITS-1:0]         head_rdata,
	input  logic [SAMPLE_BITS+POS_BITS-1:0]         back_rdata,
	output logic [$clog2(WINDOW_MAX)-1:0]           head_raddr,
	output logic [$clog2(WINDOW_MAX)-1:0]           back_raddr,
	output logic                                    we,
	output logic [$clog2(WINDOW_MAX)-1:0]           waddr,
	output logic [SAMPLE_BITS+POS_BITS-1:0]         wdata,
	input  logic                                    slot_free,
	output res_ctl_t                                res_ctl,
	output logic [SAMPLE_BITS-1:0]                  res_value
);

	localparam int AW = $clog2(WINDOW_MAX);
	localparam int OW = $clog2(WINDOW_MAX + 1);
	localparam logic [AW-1:0] TOP_IDX = AW'(WINDOW_MAX - 1);

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == TOP_IDX) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
		return (p == '0) ? TOP_IDX : p - AW'(1);
	endfunction

	state_t                        state_q, state_d;
	logic [AW-1:0]                 head_q, head_d;
	logic [AW-1:0]                 tail_q, tail_d;
	logic [OW-1:0]                 occ_q, occ_d;
	logic [POS_BITS-1:0]           sp_q, sp_d;
	logic                          filled_q, filled_d;
	logic signed [SAMPLE_BITS-1:0] s_q;
	logic                          last_q;

	logic signed [SAMPLE_BITS-1:0] back_val;
	logic [POS_BITS-1:0]           head_pos;
	logic                          drop;
	logic                          pop;
	logic                          filled_new;
	logic                          emit;

	assign back_val   = back_rdata[SAMPLE_BITS-1:0];
	assign head_pos   = head_rdata[SAMPLE_BITS +: POS_BITS];
	assign drop       = (occ_q != '0) && ((sp_q - head_pos) >= POS_BITS'(k));
	assign pop        = (occ_q != '0) && (back_val < s_q);
	assign filled_new = filled_q || (sp_q >= (POS_BITS'(k) - POS_BITS'(1)));
	assign emit       = filled_new || last_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign head_raddr = head_d;
	assign back_raddr = ring_prev(tail_d);
	assign waddr      = tail_q;
	assign wdata      = {sp_q, s_q};
	assign res_value  = (occ_q == '0) ? s_q : head_rdata[SAMPLE_BITS-1:0];

	always_comb begin
		state_d          = state_q;
		head_d           = head_q;
		tail_d           = tail_q;
		occ_d            = occ_q;
		sp_d             = sp_q;
		filled_d         = filled_q;
		we               = 1'b0;
		res_ctl.fire     = 1'b0;
		res_ctl.partial  = !filled_new;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (drop) begin
					head_d = ring_next(head_q);
					occ_d  = occ_q - OW'(1);
				end else if (pop) begin
					tail_d = ring_prev(tail_q);
					occ_d  = occ_q - OW'(1);
				end else if (!emit || slot_free) begin
					we           = 1'b1;
					res_ctl.fire = emit;
					state_d      = ST_IDLE;
					if (last_q) begin
						head_d   = '0;
						tail_d   = '0;
						occ_d    = '0;
						sp_d     = '0;
						filled_d = 1'b0;
					end else begin
						tail_d   = ring_next(tail_q);
						occ_d    = occ_q + OW'(1);
						sp_d     = sp_q + POS_BITS'(1);
						filled_d = filled_new;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			occ_q    <= '0;
			sp_q     <= '0;
			filled_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			occ_q    <= occ_d;
			sp_q     <= sp_d;
			filled_q <= filled_d;
		end
	end

	// captured transaction payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			s_q    <= sample;
			last_q <= last_item;
		end
	end

endmodule

/* hdl/sliding_window_max_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_max_top
// Streaming sliding window maximum over signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, sample, last_item): one sample per
//   transaction; last_item closes a stream and clears all deque state.
//   Output channel (out_valid, out_stall, max_value, partial): one result per
//   sample once window_size samples were seen, and always on the last item;
//   partial marks a stream that ended before the window filled.
//   Config channel (cfg_valid, cfg_ready, window_size): always ready; write
//   only between transactions. Zero acts as 1, values above WINDOW_MAX
//   saturate. Reset value is 3.
//   Each accepted sample runs a scan that drops stale front candidates and
//   pops smaller back candidates one at a time through the registered RAM
//   reads, then writes the sample and fires any result; in_stall holds off
//   the next sample until then. Back pops amortize to at most one per sample.
//   A result waits in the output register while out_stall is high; the next
//   sample is still taken, and its result holds in the sequencer until the
//   register frees up.
//   Reset: empty deque, stream position zero, no pending result.
// ----------------------------------------------------------------------------
module sliding_window_max_top import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [OUT_BITS-1:0]    max_value,
	output logic                          partial,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_BITS-1:0]           window_size
);

	localparam int AW   = $clog2(WINDOW_MAX);
	localparam int DW   = SAMPLE_BITS + POS_BITS;
	localparam int KCAP = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;

	logic [CFG_BITS-1:0]    ws_q;
	logic [CFG_BITS-1:0]    k;
	logic [AW-1:0]          head_raddr;
	logic [AW-1:0]          back_raddr;
	logic [DW-1:0]          head_rdata;
	logic [DW-1:0]          back_rdata;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [DW-1:0]          wdata;
	logic                   slot_free;
	res_ctl_t               res_ctl;
	logic [SAMPLE_BITS-1:0] res_value;
	logic                   out_valid_q;
	logic [OUT_BITS-1:0]    max_q;
	logic                   partial_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ws_q <= window_size;
		end
	end

	always_comb begin
		if (ws_q == '0) begin
			k = CFG_BITS'(1);
		end else if (ws_q > CFG_BITS'(KCAP)) begin
			k = CFG_BITS'(KCAP);
		end else begin
			k = ws_q;
		end
	end

	// two copies of the candidate ring: one read at the front, one at the back
	swm_ram #(.WIDTH(DW), .DEPTH(WINDOW_MAX)) u_ram_head (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	swm_ram #(.WIDTH(DW), .DEPTH(WINDOW_MAX)) u_ram_back (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (back_raddr),
		.rdata (back_rdata)
	);

	swm_ctrl #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.last_item  (last_item),
		.k          (k),
		.head_rdata (head_rdata),
		.back_rdata (back_rdata),
		.head_raddr (head_raddr),
		.back_raddr (back_raddr),
		.we         (we),
		.waddr      (waddr),
		.wdata      (wdata),
		.slot_free  (slot_free),
		.res_ctl    (res_ctl),
		.res_value  (res_value)
	);

	// output register
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ctl.fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ctl.fire) begin
			max_q     <= OUT_BITS'(res_value);
			partial_q <= res_ctl.partial;
		end
	end

	assign out_valid = out_valid_q;
	assign max_value = max_q;
	assign partial   = partial_q;

	// a result never overwrites one that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_ctl.fire |-> slot_free)
		else $error("result fired into a held output register");

	// results only come from the scan phase
	a_fire_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_ctl.fire |-> in_stall)
		else $error("result fired while idle");

	// every new output transaction has a source
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(res_ctl.fire))
		else $error("output valid without a result");

	// the sequencer is busy in the cycle after a sample is accepted
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("sequencer idle right after accept");

endmodule

/* tb/sliding_window_max_top_tb.sv */
// ----------------------------------------------------------------------------
// sliding_window_max_top_tb
// Self-checking bench for the sliding window maximum block. An in-bench
// monotonic deque predicts every result. Directed streams cover the default
// window, short streams, window size limits and a resize in mid-stream.
// Random streams follow with random sizes, patterns and idle cycles on both
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_max_top_tb;
	import swm_pkg::*;

	localparam int WIN_DEPTH   = WINDOW_MAX_DEF;
	localparam int IDX_BITS    = $clog2(WIN_DEPTH);
	localparam int RAND_ITEMS  = 1300;
	localparam int SETTLE_CYC  = 150;
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

	typedef enum int {
		PAT_RANDOM,
		PAT_NARROW,
		PAT_FALLING,
		PAT_EXTREME
	} sample_pattern_t;

	typedef struct packed {
		logic signed [31:0] mx;
		logic               part;
	} max_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [31:0]       sample;
	logic                     last_item;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [31:0]       max_value;
	logic                     partial;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_BITS-1:0]      window_size;

	// deque mirror
	logic signed [31:0]       cand_val [WIN_DEPTH];
	logic [31:0]              cand_pos [WIN_DEPTH];
	logic [IDX_BITS-1:0]      head_idx;
	logic [IDX_BITS-1:0]      tail_idx;
	int                       cand_count;
	logic [31:0]              pos_cnt;
	bit                       win_filled;
	logic [CFG_BITS-1:0]      win_cfg;

	max_result_t              expected_max_q [$];
	int                       err_cnt;
	int                       cycle_cnt;
	bit                       idle_on;

	sliding_window_max_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.last_item   (last_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.max_value   (max_value),
		.partial     (partial),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.window_size (window_size)
	);

	always #4 clk = ~clk;

	function automatic void clear_deque();
		head_idx   = '0;
		tail_idx   = '0;
		cand_count = 0;
		pos_cnt    = '0;
		win_filled = 1'b0;
	endfunction

	function automatic void predict_window_max(input logic signed [31:0] s, input logic last);
		int unsigned k;
		max_result_t r;
		k = win_cfg;
		if (k == 0) k = 1;
		if (k > WIN_DEPTH) k = WIN_DEPTH;
		while (cand_count > 0 && (pos_cnt - cand_pos[head_idx]) >= k) begin
			head_idx++;
			cand_count--;
		end
		while (cand_count > 0 && cand_val[IDX_BITS'(tail_idx - 1'b1)] < s) begin
			tail_idx--;
			cand_count--;
		end
		if (cand_count < WIN_DEPTH) begin
			cand_val[tail_idx] = s;
			cand_pos[tail_idx] = pos_cnt;
			tail_idx++;
			cand_count++;
		end
		if (!win_filled && pos_cnt >= k - 1) win_filled = 1'b1;
		if (win_filled || last) begin
			r.mx   = cand_val[head_idx];
			r.part = !win_filled;
			expected_max_q = {expected_max_q, r};
		end
		pos_cnt++;
		if (last) clear_deque();
	endfunction

	function automatic logic signed [31:0] pattern_sample(input sample_pattern_t pat,
			input logic signed [31:0] ramp, input int i);
		case (pat)
			PAT_NARROW:  return $signed($urandom_range(0, 6)) - 3;
			PAT_FALLING: return ramp - i;
			PAT_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return MOST_NEG;
					1: return MOST_POS;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(input logic signed [31:0] s, input logic last);
		int gap;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample    <= s;
		last_item <= last;
		do @(posedge clk); while (in_stall);
		predict_window_max(s, last);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (expected_max_q.size() > 0) @(posedge clk);
	endtask

	task automatic write_window(input int w);
		wait_all_results();
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_valid   <= 1'b1;
		window_size <= CFG_BITS'(w);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		win_cfg      = CFG_BITS'(w);
	endtask

	task automatic test_default_window();
		send_sample(MOST_NEG, 1'b0);
		send_sample(MOST_POS, 1'b0);
		send_sample(MOST_POS, 1'b0);
		send_sample(32'sd0, 1'b0);
		send_sample(-32'sd1, 1'b0);
		send_sample(MOST_NEG, 1'b0);
		send_sample(32'sd5, 1'b1);
	endtask

	task automatic test_short_streams();
		send_sample(32'sd7, 1'b1);
		send_sample(-32'sd3, 1'b0);
		send_sample(MOST_NEG, 1'b1);
	endtask

	task automatic test_window_limits();
		write_window(0);
		send_sample(32'sd1, 1'b0);
		send_sample(32'sd2, 1'b0);
		send_sample(MOST_POS, 1'b1);
		write_window(127);
		send_sample(32'sd4, 1'b0);
		send_sample(-32'sd4, 1'b0);
		send_sample(32'sd9, 1'b0);
		send_sample(32'sd9, 1'b1);
	endtask

	task automatic test_midstream_resize();
		write_window(WIN_DEPTH);
		send_sample(32'sd10, 1'b0);
		send_sample(32'sd9, 1'b0);
		write_window(1);
		send_sample(32'sd8, 1'b0);
		send_sample(32'sd3, 1'b1);
	endtask

	task automatic test_random_streams();
		int sent;
		int len;
		int k;
		int w;
		int nstr;
		sample_pattern_t pat;
		logic signed [31:0] ramp;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			case ($urandom_range(0, 9))
				0: w = 0;
				1: w = WIN_DEPTH;
				2: w = $urandom_range(WIN_DEPTH + 1, 127);
				3: w = 1;
				default: w = $urandom_range(2, 12);
			endcase
			write_window(w);
			k = (w == 0) ? 1 : ((w > WIN_DEPTH) ? WIN_DEPTH : w);
			idle_on = ($urandom_range(0, 3) != 0);
			nstr = $urandom_range(1, 4);
			for (int j = 0; j < nstr; j++) begin
				len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, k) :
				      $urandom_range(k, 2 * k + 8);
				pat  = sample_pattern_t'($urandom_range(0, 3));
				ramp = $urandom;
				for (int i = 0; i < len; i++)
					send_sample(pattern_sample(pat, ramp, i), i == len - 1);
				sent += len;
			end
			// leave a stream open so the next size change lands mid-stream
			if ($urandom_range(0, 4) == 0) begin
				len  = $urandom_range(1, 40);
				pat  = sample_pattern_t'($urandom_range(0, 3));
				ramp = $urandom;
				for (int i = 0; i < len; i++)
					send_sample(pattern_sample(pat, ramp, i), 1'b0);
				sent += len;
			end
		end
		wait_all_results();
	endtask

	// result receiver with random stall
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = idle_on ? $urandom_range(0, 13) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	always @(posedge clk) begin
		max_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_max_q.size() == 0) begin
				$display("%0t: unexpected transaction max_value %0d partial %0b",
				         $time, max_value, partial);
				err_cnt++;
			end else begin
				exp_r = expected_max_q[0];
				expected_max_q.delete(0);
				if (max_value !== exp_r.mx) begin
					$display("%0t: max_value expected %0d actual %0d",
					         $time, exp_r.mx, max_value);
					err_cnt++;
				end
				if (partial !== exp_r.part) begin
					$display("%0t: partial expected %0b actual %0b",
					         $time, exp_r.part, partial);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
			         cycle_cnt, expected_max_q.size());
			$display("** sliding_window_max_top: FAILED **");
			$finish;
		end
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		sample      = '0;
		last_item   = 1'b0;
		cfg_valid   = 1'b0;
		window_size = '0;
		err_cnt     = 0;
		cycle_cnt   = 0;
		idle_on     = 1'b1;
		win_cfg     = WS_RESET;
		clear_deque();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_short_streams();
		test_window_limits();
		test_midstream_resize();
		test_random_streams();

		repeat (SETTLE_CYC) @(posedge clk);
		if (err_cnt == 0) begin
			$display("** sliding_window_max_top: PASSED **");
		end else begin
			$display("** sliding_window_max_top: FAILED **");
		end
		$finish;
	end

endmodule

/* sliding_window_max_top.f */
hdl/swm_pkg.sv
hdl/swm_ram.sv
hdl/swm_ctrl.sv
hdl/sliding_window_max_top.sv
tb/sliding_window_max_top_tb.sv
